FILE: sv/rer_pkg.sv
// Package for the row echelon reducer: widths, register indexes, dimensions.
// No dependencies.
`default_nettype none
package rer_pkg;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned SIGN_W = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned DEF_MAX_ROWS = 8;
	localparam int unsigned DEF_MAX_COLS = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_COUNT = 2'd0,
		REG_COL_COUNT = 2'd1,
		REG_ZERO_TOL  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [DATA_W-1:0] entry_value;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] reduced_value;
		logic [SIGN_W-1:0] swap_sign;
		logic              last_entry;
	} out_item_t;
endpackage
`default_nettype wire

FILE: sv/rer_if.sv
// Valid/ready stream interface carrying one payload struct.
// No dependencies.
`default_nettype none
interface rer_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/rer_divider.sv
// Restoring divider, one quotient bit per cycle, signed truncating, 32-bit saturated.
// Depends on rer_pkg.
`default_nettype none
module rer_divider (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic signed [rer_pkg::DATA_W-1:0] numer_entry,
	input  wire logic signed [rer_pkg::DATA_W-1:0] denom,
	output logic                           done,
	output logic signed [rer_pkg::DATA_W-1:0] quot
);
	import rer_pkg::*;
	// numerator is -entry*2^16, magnitude up to 2^47
	localparam int unsigned NW = 48;
	logic [NW-1:0] rem_q, num_q;
	logic [DATA_W-1:0] den_q;
	logic [NW-1:0] q_q;
	logic [5:0] cnt_q;
	logic busy_q, neg_q;
	logic [NW:0] trial;
	logic [NW-1:0] shifted;

	assign shifted = {rem_q[NW-2:0], num_q[NW-1]};
	assign trial = {1'b0, shifted} - {{(NW+1-DATA_W){1'b0}}, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				logic signed [NW-1:0] n;
				n = -($signed({{(NW-DATA_W){numer_entry[DATA_W-1]}}, numer_entry}) <<< 16);
				num_q <= n[NW-1] ? -n : n;
				den_q <= denom[DATA_W-1] ? -denom : denom;
				// numerator sign is the opposite of the entry sign
				neg_q <= ~numer_entry[DATA_W-1] ^ denom[DATA_W-1];
				rem_q <= '0;
				q_q <= '0;
				cnt_q <= 6'(NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				num_q <= num_q << 1;
				if (!trial[NW]) begin
					rem_q <= trial[NW-1:0];
					q_q <= {q_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= shifted;
					q_q <= {q_q[NW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// sign and saturate
	always_comb begin
		logic [NW:0] s;
		s = neg_q ? -{1'b0, q_q} : {1'b0, q_q};
		if (!neg_q && q_q > 48'h7FFF_FFFF) quot = 32'sh7FFF_FFFF;
		else if (neg_q && q_q > 48'h8000_0000) quot = 32'sh8000_0000;
		else quot = s[DATA_W-1:0];
	end
endmodule
`default_nettype wire

FILE: sv/row_echelon_reducer_unit.sv
// Row echelon reducer: loads a matrix, Gaussian elimination, streams result.
// Depends on rer_pkg, rer_if and rer_divider.
//
// Usage: entries arrive on in_ch (one per transaction, row-major, signed Q16.16).
// row_count, col_count and zero_tolerance are set on the cfg port while idle.
// Loading takes one entry per cycle. After the last entry in_ch drops ready while
// a sequencer runs elimination on a shared 32x32 multiplier and a bit-serial
// divider: each factor is one 48-step division, each updated entry takes a memory
// read, a multiply and a write, and a row swap reads and writes every column.
// The reduced matrix then leaves on out_ch, one entry per transaction with the
// swap sign and a last flag; a stalling receiver just holds the output register.
// in_ch reopens after the final entry is taken. Reset clears counters, sign and
// sequencer; the matrix memory is not cleared, every read entry is first written.
`default_nettype none
module row_echelon_reducer_unit #(
	parameter int unsigned MAX_ROWS = rer_pkg::DEF_MAX_ROWS,
	parameter int unsigned MAX_COLS = rer_pkg::DEF_MAX_COLS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rer_stream_if.sink   in_ch,
	rer_stream_if.source out_ch,
	input  wire logic cfg_we,
	input  wire logic [rer_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rer_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rer_pkg::*;
	localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned RW = $clog2(MAX_ROWS + 1);
	localparam int unsigned KW = $clog2(MAX_COLS + 1);

	typedef enum logic [3:0] {
		S_LOAD, S_PIV_RD, S_PIV_CHK, S_SRCH_RD, S_SRCH_CHK, S_SWP_RD, S_SWP_WR,
		S_ROW_RD, S_DIV_GO, S_DIV, S_UPD_RD, S_UPD_MUL, S_UPD_WR, S_NEXT, S_OUT_RD, S_OUT
	} state_t;

	logic [3:0] row_cnt_q, col_cnt_q;
	logic [15:0] tol_q;
	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;
	state_t state_q;
	logic [CW-1:0] load_q, oidx_q;
	logic [RW-1:0] pr_q, kr_q, rows;
	logic [KW-1:0] pc_q, cc_q, cols;
	logic [DATA_W-1:0] piv_q, fac_q;
	logic signed [63:0] prod_q;
	logic sign_q;
	logic [CW-1:0] total;
	logic div_start, div_done;
	logic signed [DATA_W-1:0] div_quot;
	// swap sub-phases: 0 latch row k word and read pivot row word, 1 and 2 writes
	logic [1:0] swp_ph_q;
	logic [DATA_W-1:0] kw_q;

	// clamped dimensions
	always_comb begin
		rows = (row_cnt_q == 4'd0) ? RW'(1) :
			({28'd0, row_cnt_q} > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(row_cnt_q);
		cols = (col_cnt_q == 4'd0) ? KW'(1) :
			({28'd0, col_cnt_q} > MAX_COLS) ? KW'(MAX_COLS) : KW'(col_cnt_q);
		total = CW'(rows * cols);
	end

	function automatic logic [AW-1:0] addr(input logic [RW-1:0] r, input logic [KW-1:0] c,
			input logic [KW-1:0] nc);
		addr = AW'(r * nc + c);
	endfunction

	function automatic logic zero_chk(input logic [DATA_W-1:0] x, input logic [15:0] t);
		logic [DATA_W:0] m;
		m = x[DATA_W-1] ? -{1'b1, x} : {1'b0, x};
		zero_chk = m <= {17'd0, t};
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= 4'd4;
			col_cnt_q <= 4'd4;
			tol_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROW_COUNT: row_cnt_q <= cfg_data[3:0];
				REG_COL_COUNT: col_cnt_q <= cfg_data[3:0];
				REG_ZERO_TOL:  tol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// divider starts once the lower-row entry sits in rd_q
	assign div_start = (state_q == S_DIV_GO);
	rer_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .numer_entry(rd_q),
		.denom(piv_q), .done(div_done), .quot(div_quot)
	);

	assign in_ch.ready = (state_q == S_LOAD);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.data.reduced_value = rd_q;
	assign out_ch.data.swap_sign = sign_q ? 2'b11 : 2'b01;
	assign out_ch.data.last_entry = (oidx_q + CW'(1) == total);

	// memory: one write, one registered read per cycle
	logic mem_we;
	logic [AW-1:0] wa, ra;
	logic [DATA_W-1:0] wd;
	logic signed [47:0] sum;
	logic signed [47:0] pshift;
	always_comb begin
		pshift = 48'(prod_q / 64'sd65536);
		sum = {{(48-DATA_W){rd_q[DATA_W-1]}}, rd_q} + pshift;
		mem_we = 1'b0; wa = '0; wd = '0; ra = '0;
		case (state_q)
			S_LOAD: begin
				mem_we = in_ch.valid && load_q < CW'(DEPTH);
				wa = AW'(load_q); wd = in_ch.data.entry_value;
			end
			S_PIV_RD: ra = addr(pr_q, pc_q, cols);
			S_SRCH_RD: ra = addr(kr_q, pc_q, cols);
			S_SWP_RD: ra = addr(kr_q, cc_q, cols);
			S_SWP_WR: begin
				if (swp_ph_q == 2'd0) begin
					ra = addr(pr_q, cc_q, cols);
				end else if (swp_ph_q == 2'd1) begin
					mem_we = 1'b1; wa = addr(kr_q, cc_q, cols); wd = rd_q;
				end else begin
					mem_we = 1'b1; wa = addr(pr_q, cc_q, cols); wd = kw_q;
				end
			end
			S_ROW_RD: ra = addr(kr_q, pc_q, cols);
			S_UPD_RD: ra = addr(pr_q, cc_q, cols);
			S_UPD_MUL: ra = addr(kr_q, cc_q, cols);
			S_UPD_WR: begin
				mem_we = 1'b1; wa = addr(kr_q, cc_q, cols);
				if (cc_q == pc_q) wd = '0;
				else if (sum > 48'sh0000_7FFF_FFFF) wd = 32'h7FFF_FFFF;
				else if (sum < -48'sh0000_8000_0000) wd = 32'h8000_0000;
				else wd = sum[DATA_W-1:0];
			end
			S_OUT_RD: ra = AW'(oidx_q);
			S_OUT: ra = AW'(oidx_q + CW'(out_ch.ready));
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			load_q <= '0; oidx_q <= '0; sign_q <= 1'b0;
			pr_q <= '0; pc_q <= '0; kr_q <= '0; cc_q <= '0;
			swp_ph_q <= 2'd0;
		end else begin
			case (state_q)
				S_LOAD: if (in_ch.valid) begin
					if ((load_q < CW'(DEPTH) ? load_q + CW'(1) : load_q) >= total) begin
						load_q <= '0; sign_q <= 1'b0;
						pr_q <= '0; pc_q <= '0;
						state_q <= S_PIV_RD;
					end else if (load_q < CW'(DEPTH)) load_q <= load_q + CW'(1);
				end
				S_PIV_RD: begin
					if (pc_q >= cols || pr_q >= rows) begin
						oidx_q <= '0; state_q <= S_OUT_RD;
					end else state_q <= S_PIV_CHK;
				end
				S_PIV_CHK: begin
					piv_q <= rd_q; kr_q <= pr_q + RW'(1);
					if (zero_chk(rd_q, tol_q)) state_q <= S_SRCH_RD;
					else state_q <= S_NEXT;
				end
				S_SRCH_RD: begin
					if (kr_q >= rows) begin
						pc_q <= pc_q + KW'(1); state_q <= S_PIV_RD;
					end else state_q <= S_SRCH_CHK;
				end
				S_SRCH_CHK: begin
					if (!zero_chk(rd_q, tol_q)) begin
						piv_q <= rd_q; cc_q <= '0; sign_q <= ~sign_q;
						state_q <= S_SWP_RD;
					end else begin
						kr_q <= kr_q + RW'(1); state_q <= S_SRCH_RD;
					end
				end
				S_SWP_RD: state_q <= S_SWP_WR;  // rd_q <= mem[k][c]
				// swap sequencing: phase 0 reads the pivot row word, phases 1 and 2 write both words
				S_SWP_WR: begin
					if (swp_ph_q == 2'd0) begin
						swp_ph_q <= 2'd1;
					end else if (swp_ph_q == 2'd1) begin
						swp_ph_q <= 2'd2;
					end else begin
						swp_ph_q <= 2'd0;
						if (cc_q + KW'(1) >= cols) state_q <= S_NEXT;
						else begin
							cc_q <= cc_q + KW'(1); state_q <= S_SWP_RD;
						end
					end
				end
				S_NEXT: begin
					kr_q <= pr_q + RW'(1); state_q <= S_ROW_RD;
					if (pr_q + RW'(1) >= rows) begin
						pr_q <= pr_q + RW'(1); pc_q <= pc_q + KW'(1);
						state_q <= S_PIV_RD;
					end
				end
				S_ROW_RD: state_q <= S_DIV_GO;
				S_DIV_GO: state_q <= S_DIV;
				S_DIV: if (div_done) begin
					fac_q <= div_quot; cc_q <= '0; state_q <= S_UPD_RD;
				end
				S_UPD_RD: state_q <= S_UPD_MUL;
				S_UPD_MUL: begin
					prod_q <= $signed(rd_q) * $signed(fac_q);
					state_q <= S_UPD_WR;
				end
				S_UPD_WR: begin
					if (cc_q + KW'(1) >= cols) begin
						if (kr_q + RW'(1) >= rows) begin
							pr_q <= pr_q + RW'(1); pc_q <= pc_q + KW'(1);
							state_q <= S_PIV_RD;
						end else begin
							kr_q <= kr_q + RW'(1); state_q <= S_ROW_RD;
						end
					end else begin
						cc_q <= cc_q + KW'(1); state_q <= S_UPD_RD;
					end
				end
				S_OUT_RD: state_q <= S_OUT;
				S_OUT: if (out_ch.ready) begin
					if (oidx_q + CW'(1) >= total) begin
						sign_q <= 1'b0; state_q <= S_LOAD;
					end
					oidx_q <= oidx_q + CW'(1);
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// row k word held while the pivot row word is fetched
	always_ff @(posedge clk) begin
		if (state_q == S_SWP_WR && swp_ph_q == 2'd0) kw_q <= rd_q;
	end
endmodule
`default_nettype wire
